/* hdl/point_segment_distance_3d_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point-to-segment distance block.
// Each macro checks an implication on the rising edge of i_clk while the
// block is out of reset.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_3D_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PSD3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psd3 assertion failed");

// Next-cycle implication.
`define PSD3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psd3 assertion failed");

`else

`define PSD3_ASSERT_IMP(lbl, ante, cons)

`define PSD3_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* hdl/psd3_pkg.sv */
// ----------------------------------------------------------------------------
// psd3_pkg
// Widths, codes and the side-band word shared by the distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psd3_pkg;

    // Coordinate width of every input field.
    localparam int COORD_BITS = 16;

    // Signed difference of two coordinates.
    localparam int DW  = COORD_BITS + 1;
    // Signed product of two differences.
    localparam int PW  = 2 * DW;
    // Squared segment length, sum of three squares.
    localparam int L2W = 2 * COORD_BITS + 2;
    // Signed dot product, sum of three products.
    localparam int DTW = 2 * COORD_BITS + 3;

    // Projection parameter: fraction bits, width with the integer bit.
    localparam int TFB = 16;
    localparam int TW  = TFB + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << TFB;

    // Offset magnitude in units of 2^-TFB and its signed form.
    localparam int MW  = COORD_BITS + TFB + 1;
    localparam int DDW = MW + 1;
    // Split of the magnitude for the squaring partial products.
    localparam int SPL = (MW + 1) / 2;
    localparam int SHW = MW - SPL;
    // Square of one offset and sum of three squares.
    localparam int SQW = 2 * MW;
    localparam int SW  = SQW + 2;
    // Shift that turns the sum into 16 times the distance, squared.
    localparam int SCALE_SH = 2 * TFB - 8;
    localparam int SCW = SW - SCALE_SH;
    // Root width.
    localparam int RW  = (SCW + 1) / 2;

    // Distance field width.
    localparam int DIST_W = 21;

    // How the projection parameter is chosen.
    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_ONE  = 2'd1;
    localparam logic [1:0] SEL_DIV  = 2'd2;

    // Word that rides along with the divider.
    typedef struct packed {
        logic [2:0][DW-1:0] ap;
        logic [2:0][DW-1:0] ab;
        logic               degen;
        logic [1:0]         sel;
    } t_side;

endpackage

`default_nettype wire

/* hdl/psd3_div.sv */
// ----------------------------------------------------------------------------
// psd3_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd3_div import psd3_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [L2W-1:0] i_num,
    input  logic [L2W-1:0] i_den,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [TFB-1:0] o_quot,
    output t_side          o_side
);

    logic           r_v    [1:TFB];
    logic [L2W-1:0] r_rem  [1:TFB];
    logic [L2W-1:0] r_den  [1:TFB];
    logic [TFB-1:0] r_quot [1:TFB];
    t_side          r_side [1:TFB];

    for (genvar g = 0; g < TFB; g++) begin : g_stage
        logic           s_v;
        logic [L2W-1:0] s_rem;
        logic [L2W-1:0] s_den;
        logic [TFB-1:0] s_quot;
        t_side          s_side;
        logic [L2W:0]   w_sh;
        logic [L2W:0]   w_diff;
        logic [L2W-1:0] n_rem;
        logic [TFB-1:0] n_quot;

        // Stage input: the ports for the first stage, else the previous stage.
        if (g == 0) begin : g_in
            assign s_v    = i_valid;
            assign s_rem  = i_num;
            assign s_den  = i_den;
            assign s_quot = '0;
            assign s_side = i_side;
        end else begin : g_reg
            assign s_v    = r_v[g];
            assign s_rem  = r_rem[g];
            assign s_den  = r_den[g];
            assign s_quot = r_quot[g];
            assign s_side = r_side[g];
        end

        // Shift in one bit and subtract the divisor when it fits.
        always_comb begin
            w_sh   = {s_rem, 1'b0};
            w_diff = w_sh - {1'b0, s_den};
            if (w_sh >= {1'b0, s_den}) begin
                n_rem  = w_diff[L2W-1:0];
                n_quot = {s_quot[TFB-2:0], 1'b1};
            end else begin
                n_rem  = w_sh[L2W-1:0];
                n_quot = {s_quot[TFB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem;
            r_den[g+1]  <= s_den;
            r_quot[g+1] <= n_quot;
            r_side[g+1] <= s_side;
        end
    end

    assign o_valid = r_v[TFB];
    assign o_quot  = r_quot[TFB];
    assign o_side  = r_side[TFB];

endmodule

`default_nettype wire

/* hdl/psd3_sqrt.sv */
// ----------------------------------------------------------------------------
// psd3_sqrt
// Pipelined integer square root, floored: one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd3_sqrt import psd3_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic            i_degen,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic            o_degen
);

    logic            r_v    [1:RW];
    logic [2*RW-1:0] r_x    [1:RW];
    logic [RW:0]     r_rem  [1:RW];
    logic [RW-1:0]   r_root [1:RW];
    logic            r_dg   [1:RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic            s_v;
        logic [2*RW-1:0] s_x;
        logic [RW:0]     s_rem;
        logic [RW-1:0]   s_root;
        logic            s_dg;
        logic [RW+1:0]   w_cur;
        logic [RW+1:0]   w_trial;
        logic [RW+1:0]   w_diff;
        logic [RW:0]     n_rem;
        logic [RW-1:0]   n_root;

        // Stage input: the ports for the first stage, else the previous stage.
        if (g == 0) begin : g_in
            assign s_v    = i_valid;
            assign s_x    = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_dg   = i_degen;
        end else begin : g_reg
            assign s_v    = r_v[g];
            assign s_x    = r_x[g];
            assign s_rem  = r_rem[g];
            assign s_root = r_root[g];
            assign s_dg   = r_dg[g];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            w_cur   = {s_rem[RW-1:0], s_x[2*RW-1 -: 2]};
            w_trial = {s_root, 2'b01};
            w_diff  = w_cur - w_trial;
            if (w_cur >= w_trial) begin
                n_rem  = w_diff[RW:0];
                n_root = {s_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = w_cur[RW:0];
                n_root = {s_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g+1]    <= {s_x[2*RW-3:0], 2'b00};
            r_rem[g+1]  <= n_rem;
            r_root[g+1] <= n_root;
            r_dg[g+1]   <= s_dg;
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_degen = r_dg[RW];

endmodule

`default_nettype wire

/* hdl/point_segment_distance_3d_top.sv */
// A word runs from the accepting edge to the done strobe through stages 1 to
// 4, the divider, stages 5 to 9 and the square root; the divider gives one bit per
// stage over 16 stages and the square root one bit per stage over RW stages.
// Throughput: one word per clock; busy is always low, so start is taken
// every cycle. Reset is synchronous and active low; it clears every valid
// bit, so no strobe comes out of words that were in flight.
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top
// Distance from a query point to a 3-D segment, unsigned with 4 fraction
// bits, floored, with a flag for a zero-length segment.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_distance_3d_top_macros.svh"

module point_segment_distance_3d_top import psd3_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    input  logic signed [COORD_BITS-1:0] i_pt_z,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_z,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_z,
    output logic                         o_done,
    output logic [DIST_W-1:0]            o_distance,
    output logic                         o_degenerate
);

    logic [2:0][COORD_BITS-1:0] w_p;
    logic [2:0][COORD_BITS-1:0] w_a;
    logic [2:0][COORD_BITS-1:0] w_b;

    assign busy = 1'b0;
    assign w_p  = {i_pt_z, i_pt_y, i_pt_x};
    assign w_a  = {i_seg_start_z, i_seg_start_y, i_seg_start_x};
    assign w_b  = {i_seg_end_z, i_seg_end_y, i_seg_end_x};

    // Stage 1: offsets of the point and of the second end from the first end.
    logic               r_v1;
    logic [2:0][DW-1:0] r_ap1;
    logic [2:0][DW-1:0] r_ab1;
    logic [2:0][DW-1:0] n_ap1;
    logic [2:0][DW-1:0] n_ab1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ap1[i] = {w_p[i][COORD_BITS-1], w_p[i]} - {w_a[i][COORD_BITS-1], w_a[i]};
            n_ab1[i] = {w_b[i][COORD_BITS-1], w_b[i]} - {w_a[i][COORD_BITS-1], w_a[i]};
        end
    end

    // Stage 2: squares of the segment and products for the dot product.
    logic               r_v2;
    logic [2:0][PW-1:0] r_sq2;
    logic [2:0][PW-1:0] r_pd2;
    logic [2:0][DW-1:0] r_ap2;
    logic [2:0][DW-1:0] r_ab2;
    logic [2:0][PW-1:0] n_sq2;
    logic [2:0][PW-1:0] n_pd2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq2[i] = $signed(r_ab1[i]) * $signed(r_ab1[i]);
            n_pd2[i] = $signed(r_ap1[i]) * $signed(r_ab1[i]);
        end
    end

    // Stage 3: squared length and dot product.
    logic               r_v3;
    logic [L2W-1:0]     r_len3;
    logic [DTW-1:0]     r_dot3;
    logic [2:0][DW-1:0] r_ap3;
    logic [2:0][DW-1:0] r_ab3;
    logic [L2W-1:0]     n_len3;
    logic [DTW-1:0]     n_dot3;

    always_comb begin
        n_len3 = L2W'(r_sq2[0]) + L2W'(r_sq2[1]) + L2W'(r_sq2[2]);
        n_dot3 = DTW'($signed(r_pd2[0])) + DTW'($signed(r_pd2[1]))
               + DTW'($signed(r_pd2[2]));
    end

    // Stage 4: pick the clamp case and load the divider.
    logic           r_v4;
    logic [L2W-1:0] r_num4;
    logic [L2W-1:0] r_den4;
    t_side          r_side4;
    logic           w_degen;
    logic           w_dot_pos;
    logic           w_dot_ge;
    logic [1:0]     n_sel4;

    always_comb begin
        w_degen   = (r_len3 == '0);
        w_dot_pos = !r_dot3[DTW-1] && (r_dot3 != '0);
        w_dot_ge  = (r_dot3[L2W-1:0] >= r_len3);
        if (w_degen || !w_dot_pos) begin
            n_sel4 = SEL_ZERO;
        end else if (w_dot_ge) begin
            n_sel4 = SEL_ONE;
        end else begin
            n_sel4 = SEL_DIV;
        end
    end

    // Projection parameter, one quotient bit per stage.
    logic           w_dv;
    logic [TFB-1:0] w_dq;
    t_side          w_dside;

    psd3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   (r_num4),
        .i_den   (r_den4),
        .i_side  (r_side4),
        .o_valid (w_dv),
        .o_quot  (w_dq),
        .o_side  (w_dside)
    );

    // Stage 5: t times the segment, and the point offset scaled to t units.
    logic                r_v5;
    logic                r_dg5;
    logic [2:0][DDW-1:0] r_tab5;
    logic [2:0][DDW-1:0] r_aps5;
    logic [TW-1:0]       w_t;
    logic [2:0][DDW-1:0] n_tab5;
    logic [2:0][DDW-1:0] n_aps5;

    always_comb begin
        case (w_dside.sel)
            SEL_DIV: w_t = {1'b0, w_dq};
            SEL_ONE: w_t = T_ONE;
            default: w_t = '0;
        endcase
        for (int i = 0; i < 3; i++) begin
            n_tab5[i] = DDW'($signed({1'b0, w_t}) * $signed(w_dside.ab[i]));
            n_aps5[i] = DDW'($signed(w_dside.ap[i])) <<< TFB;
        end
    end

    // Stage 6: offset from the nearest point, as a magnitude.
    logic               r_v6;
    logic               r_dg6;
    logic [2:0][MW-1:0] r_mag6;
    logic [DDW-1:0]     w_d;
    logic [2:0][MW-1:0] n_mag6;

    always_comb begin
        w_d = '0;
        for (int i = 0; i < 3; i++) begin
            w_d = r_aps5[i] - r_tab5[i];
            n_mag6[i] = w_d[DDW-1] ? MW'(-w_d) : MW'(w_d);
        end
    end

    // Stage 7: partial products of each square.
    logic                  r_v7;
    logic                  r_dg7;
    logic [2:0][2*SHW-1:0] r_hh7;
    logic [2:0][MW-1:0]    r_hl7;
    logic [2:0][2*SPL-1:0] r_ll7;

    // Stage 8: each square.
    logic               r_v8;
    logic               r_dg8;
    logic [2:0][SQW-1:0] r_sq8;
    logic [2:0][SQW-1:0] n_sq8;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq8[i] = (SQW'(r_hh7[i]) << (2 * SPL)) + (SQW'(r_hl7[i]) << (SPL + 1))
                     + SQW'(r_ll7[i]);
        end
    end

    // Stage 9: sum of squares, scaled to 16 times the distance, squared.
    logic            r_v9;
    logic            r_dg9;
    logic [2*RW-1:0] r_rad9;
    logic [SW-1:0]   w_sum;

    assign w_sum = SW'(r_sq8[0]) + SW'(r_sq8[1]) + SW'(r_sq8[2]);

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= w_dv;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_ap1 <= n_ap1;
        r_ab1 <= n_ab1;
        r_sq2 <= n_sq2;
        r_pd2 <= n_pd2;
        r_ap2 <= r_ap1;
        r_ab2 <= r_ab1;
        r_len3 <= n_len3;
        r_dot3 <= n_dot3;
        r_ap3  <= r_ap2;
        r_ab3  <= r_ab2;
        r_num4 <= (n_sel4 == SEL_DIV) ? r_dot3[L2W-1:0] : '0;
        r_den4 <= r_len3;
        r_side4.ap    <= r_ap3;
        r_side4.ab    <= r_ab3;
        r_side4.degen <= w_degen;
        r_side4.sel   <= n_sel4;
        r_dg5  <= w_dside.degen;
        r_tab5 <= n_tab5;
        r_aps5 <= n_aps5;
        r_dg6  <= r_dg5;
        r_mag6 <= n_mag6;
        r_dg7  <= r_dg6;
        for (int i = 0; i < 3; i++) begin
            r_hh7[i] <= r_mag6[i][MW-1:SPL] * r_mag6[i][MW-1:SPL];
            r_hl7[i] <= r_mag6[i][MW-1:SPL] * r_mag6[i][SPL-1:0];
            r_ll7[i] <= r_mag6[i][SPL-1:0] * r_mag6[i][SPL-1:0];
        end
        r_dg8  <= r_dg7;
        r_sq8  <= n_sq8;
        r_dg9  <= r_dg8;
        r_rad9 <= (2 * RW)'(w_sum >> SCALE_SH);
    end

    // Square root, one bit per stage; its last stage drives the outputs.
    logic                 w_sv;
    logic [RW-1:0]        w_root;
    logic                 w_sdg;
    logic [RW+DIST_W-1:0] w_root_ext;

    psd3_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v9),
        .i_rad   (r_rad9),
        .i_degen (r_dg9),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_degen (w_sdg)
    );

    assign w_root_ext   = (RW + DIST_W)'(w_root);
    assign o_done       = w_sv;
    assign o_distance   = w_root_ext[DIST_W-1:0];
    assign o_degenerate = w_sdg;

    // A zero-length segment always takes the first end point.
    `PSD3_ASSERT_IMP(a_degen_sel, r_v4 && r_side4.degen, r_side4.sel == SEL_ZERO)
    // A word leaving the divider enters the offset stage next cycle.
    `PSD3_ASSERT_NXT(a_div_flow, w_dv, r_v5)
    // A strobe comes only from a word that reached the root pipeline.
    `PSD3_ASSERT_IMP(a_sqrt_flow, o_done, $past(r_v9, RW))

endmodule

`default_nettype wire
